### rtl/core/vnorm_pkg.sv
package vnorm_pkg;

    // input and fraction formats
    localparam int IN_W   = 16;
    localparam int FRAC   = 14;
    localparam int OUT_W  = 16;
    localparam int EPS_W  = 15;
    // result magnitude holds 0 .. 2^FRAC
    localparam int QW     = FRAC + 1;
    localparam int KW     = $clog2(QW);
    localparam int MAG_W  = IN_W;
    localparam int SQ_W   = 2 * IN_W - 1;
    localparam int S_W    = 2 * IN_W;
    // residual width, covers each square shifted by 2*FRAC+2 with margin
    localparam int ACC_W  = 2 * IN_W + 2 * FRAC + 8;

    typedef logic signed [ACC_W-1:0] acc_t;

    // one component's bit search state
    typedef struct packed {
        acc_t            rem;    // R - (2q-1)^2 * s
        acc_t            prod;   // (2q-1) * s
        logic [QW-1:0]   q;
        logic            neg;
    } lane_t;

    // one beat moving through the search stages
    typedef struct packed {
        lane_t [2:0]     lane;
        logic [S_W-1:0]  s;
        logic            zero;
    } item_t;

endpackage

### rtl/core/vnorm_front.sv
module vnorm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [vnorm_pkg::IN_W-1:0] in_x,
    input  logic [vnorm_pkg::IN_W-1:0] in_y,
    input  logic [vnorm_pkg::IN_W-1:0] in_z,
    output logic                       out_valid,
    output vnorm_pkg::item_t           out_item
);

    logic [vnorm_pkg::IN_W-1:0]  raw_reg [3];
    logic                        va_reg, vb_reg, vc_reg;
    logic [vnorm_pkg::MAG_W-1:0] mag [3];
    logic [vnorm_pkg::SQ_W-1:0]  sq_reg [3];
    logic [2:0]                  negb_reg;
    logic [vnorm_pkg::S_W-1:0]   s_sum;
    vnorm_pkg::item_t            item_next, item_reg;

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // magnitude of each component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (raw_reg[i][vnorm_pkg::IN_W-1])
                mag[i] = vnorm_pkg::MAG_W'(~raw_reg[i] + 1'b1);
            else
                mag[i] = raw_reg[i];
        end
    end

    // input and square stages
    always_ff @(posedge clk)
    begin
        raw_reg[0] <= in_x;
        raw_reg[1] <= in_y;
        raw_reg[2] <= in_z;
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i]   <= vnorm_pkg::SQ_W'(mag[i] * mag[i]);
            negb_reg[i] <= raw_reg[i][vnorm_pkg::IN_W-1];
        end
        item_reg <= item_next;
    end

    // sum of squares and initial residuals
    always_comb
    begin
        s_sum = vnorm_pkg::S_W'(sq_reg[0]) + vnorm_pkg::S_W'(sq_reg[1])
              + vnorm_pkg::S_W'(sq_reg[2]);
        item_next.s    = s_sum;
        item_next.zero = (s_sum == '0);
        for (int i = 0; i < 3; i++)
        begin
            item_next.lane[i].rem  = (vnorm_pkg::ACC_W'(sq_reg[i]) <<< (2 * vnorm_pkg::FRAC + 2))
                                   - vnorm_pkg::ACC_W'(s_sum);
            item_next.lane[i].prod = -vnorm_pkg::acc_t'(vnorm_pkg::ACC_W'(s_sum));
            item_next.lane[i].q    = '0;
            item_next.lane[i].neg  = negb_reg[i];
        end
    end

    assign out_valid = vc_reg;
    assign out_item  = item_reg;

endmodule

### rtl/core/vnorm_step.sv
module vnorm_step (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [vnorm_pkg::KW-1:0] k,
    input  logic                     in_valid,
    input  vnorm_pkg::item_t         in_item,
    output logic                     out_valid,
    output vnorm_pkg::item_t         out_item
);

    logic                  valid_reg;
    vnorm_pkg::item_t      item_next, item_reg;
    vnorm_pkg::acc_t       s_ext;
    vnorm_pkg::acc_t       term [3];
    vnorm_pkg::acc_t       trial [3];
    logic [vnorm_pkg::KW+1:0] sh1, sh2, sh3;

    // try setting bit k of each magnitude
    always_comb
    begin
        s_ext     = vnorm_pkg::ACC_W'(in_item.s);
        sh1       = (vnorm_pkg::KW+2)'(k) + 1'b1;
        sh2       = (vnorm_pkg::KW+2)'(k) + 2'd2;
        sh3       = ((vnorm_pkg::KW+2)'(k) << 1) + 2'd2;
        item_next = in_item;
        for (int i = 0; i < 3; i++)
        begin
            term[i]  = (in_item.lane[i].prod <<< sh2) + (s_ext <<< sh3);
            trial[i] = in_item.lane[i].rem - term[i];
            if (!trial[i][vnorm_pkg::ACC_W-1])
            begin
                item_next.lane[i].rem  = trial[i];
                item_next.lane[i].prod = in_item.lane[i].prod + (s_ext <<< sh1);
                item_next.lane[i].q    = in_item.lane[i].q
                                       | (vnorm_pkg::QW'(1) << k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### rtl/core/vector_normalize_axis_flags.sv
// throughput: one vector per cycle; busy is never raised
// a 3-stage front end forms the sum of squares, then 15 one-bit search stages
// decide each magnitude bit, then one output stage applies sign and flags
// reset: async active-low, clears all valid bits and sets eps_reg to 1
module vector_normalize_axis_flags (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [15:0]            dir_x,
    input  logic signed [15:0]            dir_y,
    input  logic signed [15:0]            dir_z,
    input  logic                          cfg_we,
    input  logic [vnorm_pkg::EPS_W-1:0]   cfg_wdata,
    output logic                          done,
    output logic signed [15:0]            unit_x,
    output logic signed [15:0]            unit_y,
    output logic signed [15:0]            unit_z,
    output logic [2:0]                    parallel_mask,
    output logic                          zero_length
);

    logic [vnorm_pkg::EPS_W-1:0] eps_reg;
    logic                        pv [vnorm_pkg::QW+1];
    vnorm_pkg::item_t            pi [vnorm_pkg::QW+1];
    logic                        done_reg;
    logic [vnorm_pkg::OUT_W-1:0] unit_next [3];
    logic [vnorm_pkg::OUT_W-1:0] unit_reg [3];
    logic [2:0]                  mask_next, mask_reg;
    logic                        zero_reg;

    assign busy = 1'b0;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= vnorm_pkg::EPS_W'(1);
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    vnorm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_x      (dir_x),
        .in_y      (dir_y),
        .in_z      (dir_z),
        .out_valid (pv[0]),
        .out_item  (pi[0])
    );

    // one stage per result bit, msb first
    for (genvar g = 0; g < vnorm_pkg::QW; g++)
    begin : g_step
        vnorm_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .k         (vnorm_pkg::KW'(vnorm_pkg::QW - 1 - g)),
            .in_valid  (pv[g]),
            .in_item   (pi[g]),
            .out_valid (pv[g+1]),
            .out_item  (pi[g+1])
        );
    end

    // sign, threshold and zero-length handling
    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (pi[vnorm_pkg::QW].zero)
                unit_next[i] = '0;
            else if (pi[vnorm_pkg::QW].lane[i].neg)
                unit_next[i] = -vnorm_pkg::OUT_W'(pi[vnorm_pkg::QW].lane[i].q);
            else
                unit_next[i] = vnorm_pkg::OUT_W'(pi[vnorm_pkg::QW].lane[i].q);
            mask_next[i] = !pi[vnorm_pkg::QW].zero
                         && (vnorm_pkg::EPS_W'(pi[vnorm_pkg::QW].lane[i].q) < eps_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pv[vnorm_pkg::QW];
    end

    always_ff @(posedge clk)
    begin
        unit_reg[0] <= unit_next[0];
        unit_reg[1] <= unit_next[1];
        unit_reg[2] <= unit_next[2];
        mask_reg    <= mask_next;
        zero_reg    <= pi[vnorm_pkg::QW].zero;
    end

    assign done          = done_reg;
    assign unit_x        = unit_reg[0];
    assign unit_y        = unit_reg[1];
    assign unit_z        = unit_reg[2];
    assign parallel_mask = mask_reg;
    assign zero_length   = zero_reg;

endmodule
